// ----- sv/zhvc_pkg.sv -----
package zhvc_pkg;

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_COOL = 2'd1,
		MODE_HEAT = 2'd2
	} hvac_mode_t;

	typedef enum logic [1:0] {
		KIND_HVAC   = 2'd0,
		KIND_VENT   = 2'd1,
		KIND_STATUS = 2'd2
	} out_kind_t;

	typedef enum logic [1:0] {
		REQ_SET_CUR  = 2'd0,
		REQ_SET_TGT  = 2'd1,
		REQ_SET_VENT = 2'd2,
		REQ_SET_ADDR = 2'd3
	} req_type_t;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_REJECTED = 2'd1;
	localparam logic [1:0] VENT_CLOSE      = 2'd0;
	localparam logic [1:0] VENT_OPEN       = 2'd1;

	typedef struct packed {
		logic signed [15:0] cur_temp;
		logic signed [15:0] tgt_temp;
		logic               vent_open;
		logic        [7:0]  vent_addr;
	} zone_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MODIFY,
		ST_PASS1,
		ST_DECIDE,
		ST_PASS2,
		ST_STATUS
	} ctrl_state_t;

endpackage

// ----- sv/zhvc_ram.sv -----
module zhvc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/zoned_hvac_vent_controller_top.sv -----
// Zone table controller for vents and the HVAC unit. Each accepted update writes one field
// of one zone through a read-modify-write of the zone table. Rejected updates and vent
// address writes skip the passes over the table. Temperature and vent-state writes make
// two passes over the n zones in use (hot/cold count, then vent commands); the table has
// one read port and each pass reads one zone per cycle, except that the second pass stalls
// while a vent command waits on out_ready. Every update ends with one status result
// with last set. Zones never written read as zero and closed.
module zoned_hvac_vent_controller_top
	import zhvc_pkg::*;
#(
	parameter int NUM_ZONES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [4:0]         cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [3:0]         zone_index,
	input  logic signed [15:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         kind,
	output logic [7:0]         device_address,
	output logic [1:0]         command_value,
	output logic               last
);

	localparam int AW = NUM_ZONES > 1 ? $clog2(NUM_ZONES) : 1;
	localparam int CW = $clog2(NUM_ZONES + 1);
	localparam int EW = $bits(zone_entry_t);

	ctrl_state_t        state_q, state_d;
	logic [4:0]         zone_count_q;
	logic [CW-1:0]      n_zones;
	req_type_t          req_type_q;
	logic signed [15:0] req_value_q;
	logic [AW-1:0]      req_idx_q;
	logic               reject_q;
	hvac_mode_t         mode_q, mode_new;
	logic               mode_emit;
	logic [CW-1:0]      hot_q, cold_q;
	logic [CW-1:0]      rd_idx_q;
	logic               p_s1_q;
	logic [AW-1:0]      idx_s1_q;
	logic               vld_s1_q;
	logic [NUM_ZONES-1:0] vld_q;

	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [EW-1:0]      ram_wdata, ram_rdata;

	zone_entry_t        ent_rd, mod_ent;
	logic               in_fire, reject_in, out_can_load, issue_more;
	logic               is_hot, is_cold, want, vent_diff, pass_adv;

	logic               out_valid_q, out_load;
	out_kind_t          out_kind_q, out_kind_d;
	logic [7:0]         out_addr_q, out_addr_d;
	logic [1:0]         out_cmd_q, out_cmd_d;
	logic               out_last_q, out_last_d;

	zhvc_ram #(
		.WIDTH(EW),
		.DEPTH(NUM_ZONES)
	) u_zone_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		if (32'(zone_count_q) >= NUM_ZONES) begin
			n_zones = CW'(NUM_ZONES);
		end else begin
			n_zones = CW'(zone_count_q);
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign in_fire      = in_valid && in_ready;
	assign reject_in    = 32'(zone_index) >= 32'(n_zones);
	assign out_can_load = !out_valid_q || out_ready;
	assign issue_more   = rd_idx_q < n_zones;

	// entries never written read as reset values
	assign ent_rd  = vld_s1_q ? zone_entry_t'(ram_rdata) : '0;
	assign is_hot  = $signed(ent_rd.cur_temp) > $signed(ent_rd.tgt_temp);
	assign is_cold = $signed(ent_rd.cur_temp) < $signed(ent_rd.tgt_temp);

	always_comb begin
		if (is_hot) begin
			want = (mode_q == MODE_COOL);
		end else if (is_cold) begin
			want = (mode_q == MODE_HEAT);
		end else begin
			want = 1'b0;
		end
	end

	assign vent_diff = want != ent_rd.vent_open;

	always_comb begin
		mod_ent = ent_rd;
		unique case (req_type_q)
			REQ_SET_CUR:  mod_ent.cur_temp  = req_value_q;
			REQ_SET_TGT:  mod_ent.tgt_temp  = req_value_q;
			REQ_SET_VENT: mod_ent.vent_open = |req_value_q;
			REQ_SET_ADDR: mod_ent.vent_addr = req_value_q[7:0];
			default:      mod_ent           = ent_rd;
		endcase
	end

	always_comb begin
		mode_new  = mode_q;
		mode_emit = 1'b0;
		priority if (hot_q == '0 && cold_q == '0) begin
			mode_new  = MODE_OFF;
			mode_emit = 1'b1;
		end else if (mode_q == MODE_OFF || hot_q == '0 || cold_q == '0) begin
			mode_new  = (hot_q >= cold_q) ? MODE_COOL : MODE_HEAT;
			mode_emit = 1'b1;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = reject_in ? ST_STATUS : ST_MODIFY;
				end
			end
			ST_MODIFY: begin
				state_d = (req_type_q == REQ_SET_ADDR) ? ST_STATUS : ST_PASS1;
			end
			ST_PASS1: begin
				if (!issue_more && !p_s1_q) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (!mode_emit || out_can_load) begin
					state_d = ST_PASS2;
				end
			end
			ST_PASS2: begin
				if (!issue_more && !p_s1_q) begin
					state_d = ST_STATUS;
				end
			end
			ST_STATUS: begin
				if (out_can_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// table access and result loading
	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = idx_s1_q;
		ram_wdata  = ent_rd;
		ram_re     = 1'b0;
		ram_raddr  = rd_idx_q[AW-1:0];
		pass_adv   = 1'b0;
		out_load   = 1'b0;
		out_kind_d = KIND_STATUS;
		out_addr_d = '0;
		out_cmd_d  = STATUS_OK;
		out_last_d = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ram_raddr = AW'(zone_index);
				ram_re    = in_fire && !reject_in;
			end
			ST_MODIFY: begin
				ram_we    = 1'b1;
				ram_waddr = req_idx_q;
				ram_wdata = mod_ent;
			end
			ST_PASS1: begin
				ram_re = issue_more;
			end
			ST_DECIDE: begin
				out_load   = mode_emit && out_can_load;
				out_kind_d = KIND_HVAC;
				out_cmd_d  = mode_new;
			end
			ST_PASS2: begin
				pass_adv = !p_s1_q || !vent_diff || out_can_load;
				ram_re   = pass_adv && issue_more;
				if (p_s1_q && vent_diff && out_can_load) begin
					ram_we     = 1'b1;
					ram_wdata  = {ent_rd.cur_temp, ent_rd.tgt_temp, want, ent_rd.vent_addr};
					out_load   = 1'b1;
					out_kind_d = KIND_VENT;
					out_addr_d = ent_rd.vent_addr;
					out_cmd_d  = want ? VENT_OPEN : VENT_CLOSE;
				end
			end
			ST_STATUS: begin
				out_load   = out_can_load;
				out_kind_d = KIND_STATUS;
				out_cmd_d  = reject_q ? STATUS_REJECTED : STATUS_OK;
				out_last_d = 1'b1;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			zone_count_q <= '0;
			reject_q     <= 1'b0;
			mode_q       <= MODE_OFF;
			hot_q        <= '0;
			cold_q       <= '0;
			rd_idx_q     <= '0;
			p_s1_q       <= 1'b0;
			vld_s1_q     <= 1'b0;
			vld_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				zone_count_q <= cfg_wr_data;
			end
			if (in_fire) begin
				reject_q <= reject_in;
			end
			if (ram_re) begin
				vld_s1_q <= vld_q[ram_raddr];
			end
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (state_q == ST_DECIDE && mode_emit && out_can_load) begin
				mode_q <= mode_new;
			end

			if (state_q == ST_PASS1) begin
				p_s1_q <= ram_re;
				if (ram_re) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
				if (p_s1_q && is_hot) begin
					hot_q <= hot_q + CW'(1);
				end
				if (p_s1_q && is_cold) begin
					cold_q <= cold_q + CW'(1);
				end
			end else if (state_q == ST_PASS2) begin
				if (pass_adv) begin
					p_s1_q <= ram_re;
				end
				if (ram_re) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
			end else begin
				rd_idx_q <= '0;
				p_s1_q   <= 1'b0;
				if (state_q == ST_MODIFY) begin
					hot_q  <= '0;
					cold_q <= '0;
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_type_q  <= req_type_t'(req_type);
			req_idx_q   <= AW'(zone_index);
			req_value_q <= value;
		end
		if (ram_re) begin
			idx_s1_q <= ram_raddr;
		end
		if (out_load) begin
			out_kind_q <= out_kind_d;
			out_addr_q <= out_addr_d;
			out_cmd_q  <= out_cmd_d;
			out_last_q <= out_last_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = out_kind_q;
	assign device_address = out_addr_q;
	assign command_value  = out_cmd_q;
	assign last           = out_last_q;

	// write-back never targets the entry being read
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_re |-> ram_waddr != ram_raddr)
		else $error("table write and read hit the same entry");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PASS1 || state_q == ST_PASS2) |-> rd_idx_q <= n_zones)
		else $error("scan index beyond zones in use");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PASS1 || state_q == ST_DECIDE) |->
		(CW + 1)'(hot_q) + (CW + 1)'(cold_q) <= (CW + 1)'(n_zones))
		else $error("hot and cold counts exceed zones in use");

	a_status_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && out_last_d |=> state_q == ST_IDLE && out_valid_q)
		else $error("status transfer loaded without returning to idle");

endmodule
